[src/pkwc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pkwc_pkg
// Shared widths, constants and types of the position keyed word cipher.
// ----------------------------------------------------------------------------
package pkwc_pkg;

   localparam int WORD_W      = 32;
   localparam int POS_W       = 34;
   localparam int KEY_COUNT   = 8;
   localparam int KEY_SEL_W   = 3;
   localparam int HIGH_SHIFT  = 5;
   localparam int CSR_IDX_W   = 4;
   localparam int CSR_DATA_W  = 64;
   localparam int QUEUE_DEPTH = 4;

   // one key register: key0 in the low half, key1 in the high half
   typedef struct packed {
      logic [WORD_W-1:0] key1;
      logic [WORD_W-1:0] key0;
   } key_pair_type;

   typedef key_pair_type [KEY_COUNT-1:0] key_file_type;

   // one word after the front end has fixed its stream position
   typedef struct packed {
      logic [POS_W-1:0]  pos;
      logic [WORD_W-1:0] data;
      logic              last;
   } queue_entry_type;

endpackage

[src/position_keyed_word_cipher.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// position_keyed_word_cipher
// XOR keystream coder over 32-bit words keyed by a 34-bit word position.
// ----------------------------------------------------------------------------
//  channel | ports                                   | direction
//  --------+-----------------------------------------+----------
//  req     | valid/ready, set_position, word_offset, | in
//          | data_word, last_word                    |
//  rsp     | valid/ready, coded_word, last_out       | out
//  csr     | wr_en, index, wdata (64 bits)           | in
//
//  one transaction per cycle sustained while rsp is not stalled; the front end takes a word each cycle
//  from req acceptance to rsp_valid a word goes through the queue write at the
//  accepting edge, then the product stage, then the output stage
//  reset clears the position counter, the key registers and the queue
//  a stalled rsp backs up through the queue; req_ready drops once it is full
// ----------------------------------------------------------------------------
module position_keyed_word_cipher #(
   parameter int QUEUE_DEPTH = pkwc_pkg::QUEUE_DEPTH
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic                             req_set_position,
   input  logic [pkwc_pkg::WORD_W-1:0]      req_word_offset,
   input  logic [pkwc_pkg::WORD_W-1:0]      req_data_word,
   input  logic                             req_last_word,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [pkwc_pkg::WORD_W-1:0]      rsp_coded_word,
   output logic                             rsp_last_out,
   input  logic                             csr_wr_en,
   input  logic [pkwc_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [pkwc_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import pkwc_pkg::*;

   key_file_type    key_ff;
   queue_entry_type push_entry, head_entry;
   logic            queue_full, queue_push, queue_pop, queue_not_empty;

   // writes beyond the key registers are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff <= '0;
      end else if (csr_wr_en && (csr_index < CSR_IDX_W'(KEY_COUNT))) begin
         key_ff[csr_index[KEY_SEL_W-1:0]] <= key_pair_type'(csr_wdata);
      end
   end

   pkwc_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_set_position (req_set_position),
      .req_word_offset  (req_word_offset),
      .req_data_word    (req_data_word),
      .req_last_word    (req_last_word),
      .key0_base        (key_ff[0].key0),
      .queue_full       (queue_full),
      .queue_push       (queue_push),
      .queue_entry      (push_entry)
   );

   pkwc_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (queue_push),
      .push_entry (push_entry),
      .full       (queue_full),
      .pop        (queue_pop),
      .not_empty  (queue_not_empty),
      .head_entry (head_entry)
   );

   pkwc_back u_back (
      .clock           (clock),
      .reset           (reset),
      .key_file        (key_ff),
      .queue_not_empty (queue_not_empty),
      .queue_head      (head_entry),
      .queue_pop       (queue_pop),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_coded_word  (rsp_coded_word),
      .rsp_last_out    (rsp_last_out)
   );

endmodule

[src/pkwc_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pkwc_front
// Accepts request transactions and tags each word with its stream position.
// ----------------------------------------------------------------------------
module pkwc_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic                          req_set_position,
   input  logic [pkwc_pkg::WORD_W-1:0]   req_word_offset,
   input  logic [pkwc_pkg::WORD_W-1:0]   req_data_word,
   input  logic                          req_last_word,
   input  logic [pkwc_pkg::WORD_W-1:0]   key0_base,
   input  logic                          queue_full,
   output logic                          queue_push,
   output pkwc_pkg::queue_entry_type     queue_entry
);
   import pkwc_pkg::*;

   logic [POS_W-1:0] pos_ff;
   logic [POS_W-1:0] pos_in;
   logic [POS_W-1:0] pos_cur;
   logic             accept;

   assign req_ready = !queue_full;
   assign accept    = req_valid && !queue_full;

   // a position load applies to the word that carries it
   assign pos_cur = req_set_position ?
                    (POS_W'(req_word_offset) + POS_W'(key0_base)) : pos_ff;
   assign pos_in  = accept ? (pos_cur + POS_W'(1)) : pos_ff;

   assign queue_push       = accept;
   assign queue_entry.pos  = pos_cur;
   assign queue_entry.data = req_data_word;
   assign queue_entry.last = req_last_word;

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
      end else begin
         pos_ff <= pos_in;
      end
   end

   a_pos_increments: assert property (@(posedge clock) disable iff (reset)
      accept && !req_set_position |=> pos_ff == $past(pos_ff) + POS_W'(1))
      else $error("position counter did not step");

   a_pos_loads: assert property (@(posedge clock) disable iff (reset)
      accept && req_set_position |=>
         pos_ff == POS_W'($past(req_word_offset)) + POS_W'($past(key0_base)) + POS_W'(1))
      else $error("position load went wrong");

   a_pos_idle: assert property (@(posedge clock) disable iff (reset)
      !accept |=> $stable(pos_ff))
      else $error("position moved without a transaction");

endmodule

[src/pkwc_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pkwc_queue
// Short FIFO between the position front end and the keystream back end.
// ----------------------------------------------------------------------------
module pkwc_queue #(
   parameter int DEPTH = pkwc_pkg::QUEUE_DEPTH
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  pkwc_pkg::queue_entry_type  push_entry,
   output logic                       full,
   input  logic                       pop,
   output logic                       not_empty,
   output pkwc_pkg::queue_entry_type  head_entry
);
   import pkwc_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   queue_entry_type    entry_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;

   assign full       = (count_ff == CNT_W'(DEPTH));
   assign not_empty  = (count_ff != '0);
   assign head_entry = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_entry;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !full)
      else $error("push into a full queue");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> not_empty)
      else $error("pop from an empty queue");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("queue count out of range");

endmodule

[src/pkwc_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pkwc_back
// Keystream back end: key select and two products, then add, xor and output.
// ----------------------------------------------------------------------------
module pkwc_back (
   input  logic                         clock,
   input  logic                         reset,
   input  pkwc_pkg::key_file_type       key_file,
   input  logic                         queue_not_empty,
   input  pkwc_pkg::queue_entry_type    queue_head,
   output logic                         queue_pop,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [pkwc_pkg::WORD_W-1:0]  rsp_coded_word,
   output logic                         rsp_last_out
);
   import pkwc_pkg::*;

   // product stage
   logic              s1_vld_ff;
   logic [WORD_W-1:0] s1_lo_ff, s1_hi_ff, s1_data_ff;
   logic              s1_last_ff;
   // output stage
   logic              s2_vld_ff;
   logic [WORD_W-1:0] s2_word_ff;
   logic              s2_last_ff;

   key_pair_type      key_sel;
   logic [WORD_W-1:0] hi_op;
   logic [WORD_W-1:0] lo_prod, hi_prod;
   logic              s2_load, s1_go, s1_load;

   assign s2_load   = !s2_vld_ff || rsp_ready;
   assign s1_go     = s1_vld_ff && s2_load;
   assign s1_load   = !s1_vld_ff || s1_go;
   assign queue_pop = queue_not_empty && s1_load;

   assign key_sel = key_file[queue_head.pos[KEY_SEL_W-1:0]];
   assign hi_op   = WORD_W'(queue_head.pos >> HIGH_SHIFT);
   // only the low word of each product matters
   assign lo_prod = WORD_W'(queue_head.pos[WORD_W-1:0] * key_sel.key0);
   assign hi_prod = WORD_W'(hi_op * key_sel.key1);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
      end else begin
         if (s1_load) begin
            s1_vld_ff <= queue_pop;
         end
         if (s2_load) begin
            s2_vld_ff <= s1_vld_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (queue_pop) begin
         s1_lo_ff   <= lo_prod;
         s1_hi_ff   <= hi_prod;
         s1_data_ff <= queue_head.data;
         s1_last_ff <= queue_head.last;
      end
      if (s1_go) begin
         s2_word_ff <= s1_data_ff ^ (s1_lo_ff + s1_hi_ff);
         s2_last_ff <= s1_last_ff;
      end
   end

   assign rsp_valid      = s2_vld_ff;
   assign rsp_coded_word = s2_word_ff;
   assign rsp_last_out   = s2_last_ff;

   a_s1_holds: assert property (@(posedge clock) disable iff (reset)
      s1_vld_ff && !s2_load |=> s1_vld_ff && $stable(s1_data_ff) && $stable(s1_lo_ff))
      else $error("product stage lost a word under stall");

   a_pop_has_room: assert property (@(posedge clock) disable iff (reset)
      queue_pop |-> (!s1_vld_ff || s1_go))
      else $error("pop while product stage is blocked");

   a_s2_fill: assert property (@(posedge clock) disable iff (reset)
      s1_go |=> s2_vld_ff)
      else $error("word did not reach the output stage");

endmodule

[tb/position_keyed_word_cipher_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// position_keyed_word_cipher_tb
// Streams words through the cipher under several key settings and checks each
// coded word and last flag against a position and keystream model kept here.
// Directed words hit position loads, selector cycling and the highest loadable
// position. Random buffers follow with random idles on the request side and
// random back-pressure on the response side.
// ----------------------------------------------------------------------------
module position_keyed_word_cipher_tb;
   import pkwc_pkg::*;

   localparam int LATENCY        = 2;
   localparam int SETTLE_CYCLES  = LATENCY + 2;
   localparam int END_WAIT_LIMIT = 20000;

   localparam logic [CSR_IDX_W-1:0] KEY_PAIR_0_IDX  = '0;
   localparam logic [CSR_IDX_W-1:0] FIRST_SPARE_IDX = CSR_IDX_W'(KEY_COUNT);
   localparam logic [CSR_IDX_W-1:0] LAST_SPARE_IDX  = '1;

   typedef enum {KEYS_ZERO, KEYS_ONES, KEYS_RANDOM} key_pattern_type;

   typedef struct packed {
      logic [WORD_W-1:0] coded;
      logic              last;
   } coded_result_type;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_ready;
   logic                  req_set_position;
   logic [WORD_W-1:0]     req_word_offset;
   logic [WORD_W-1:0]     req_data_word;
   logic                  req_last_word;
   logic                  rsp_valid;
   logic                  rsp_ready;
   logic [WORD_W-1:0]     rsp_coded_word;
   logic                  rsp_last_out;
   logic                  csr_wr_en;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   coded_result_type pending_results[$];
   key_file_type     cipher_keys;
   logic [POS_W-1:0] word_position;
   bit               sender_idles;
   bit               receiver_stalls;
   int               words_driven;
   int               results_checked;
   int               mismatch_count;
   int               key_settings;

   position_keyed_word_cipher u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_set_position (req_set_position),
      .req_word_offset  (req_word_offset),
      .req_data_word    (req_data_word),
      .req_last_word    (req_last_word),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_coded_word   (rsp_coded_word),
      .rsp_last_out     (rsp_last_out),
      .csr_wr_en        (csr_wr_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   initial clock = 1'b0;
   always #6 clock = ~clock;

   // mostly back-to-back, some short gaps, a few long ones
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 60) return 0;
      if (roll < 90) return $urandom_range(1, 3);
      if (roll < 98) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [WORD_W-1:0] pick_offset();
      int roll;
      roll = $urandom_range(0, 7);
      if (roll == 0) return $urandom_range(0, 40);
      if (roll == 1) return 32'hFFFF_FFFF - $urandom_range(0, 40);
      return $urandom;
   endfunction

   // response side back-pressure
   initial begin : rsp_side
      int stall;
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         stall = (receiver_stalls && $urandom_range(0, 3) == 0) ? pick_gap() : 0;
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_ready <= 1'b1;
      end
   end

   // check the response first, then model the request accepted at the same edge
   always @(posedge clock) begin
      coded_result_type want;
      coded_result_type got;
      key_pair_type     key;
      logic [WORD_W-1:0] low_term;
      logic [WORD_W-1:0] high_term;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_results.size() == 0) begin
            mismatch_count++;
            $display("%0t: unexpected transaction, coded_word %h last_out %b",
                     $time, rsp_coded_word, rsp_last_out);
         end else begin
            want = pending_results.pop_front();
            if (rsp_coded_word !== want.coded) begin
               mismatch_count++;
               $display("%0t: coded_word expected %h actual %h",
                        $time, want.coded, rsp_coded_word);
            end
            if (rsp_last_out !== want.last) begin
               mismatch_count++;
               $display("%0t: last_out expected %b actual %b",
                        $time, want.last, rsp_last_out);
            end
         end
         results_checked++;
      end
      if (!reset && req_valid && req_ready) begin
         // load happens before this word is coded; the sum keeps its carry
         if (req_set_position)
            word_position = req_word_offset
                            + cipher_keys[KEY_PAIR_0_IDX[KEY_SEL_W-1:0]].key0;
         key = cipher_keys[word_position[KEY_SEL_W-1:0]];
         low_term  = word_position[WORD_W-1:0] * key.key0;
         high_term = (word_position >> HIGH_SHIFT) * key.key1;
         got.coded = req_data_word ^ (low_term + high_term);
         got.last  = req_last_word;
         pending_results.push_back(got);
         word_position = word_position + 1'b1;
      end
   end

   task automatic send_word(input logic set_pos, input logic [WORD_W-1:0] offset,
                            input logic [WORD_W-1:0] data, input logic last);
      int gap;
      gap = sender_idles ? pick_gap() : 0;
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid        <= 1'b1;
      req_set_position <= set_pos;
      req_word_offset  <= offset;
      req_data_word    <= data;
      req_last_word    <= last;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      words_driven++;
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(negedge clock);
   endtask

   task automatic quiesce();
      wait_drained();
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_key_pair(input logic [CSR_IDX_W-1:0] index,
                                 input logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      if (index < FIRST_SPARE_IDX) cipher_keys[index[KEY_SEL_W-1:0]] = value;
   endtask

   task automatic load_keys(input key_pattern_type pattern);
      logic [CSR_DATA_W-1:0] value;
      logic [CSR_IDX_W-1:0]  index;
      quiesce();
      for (int i = 0; i < KEY_COUNT; i++) begin
         case (pattern)
            KEYS_ZERO: value = '0;
            KEYS_ONES: value = '1;
            default:   value = {$urandom, $urandom};
         endcase
         index = CSR_IDX_W'(i);
         write_key_pair(index, value);
      end
      // a write past the key file must leave every key alone
      index = CSR_IDX_W'($urandom_range(FIRST_SPARE_IDX, LAST_SPARE_IDX));
      write_key_pair(index, {$urandom, $urandom});
      key_settings++;
   endtask

   // keys are zero out of reset, so every word passes through unchanged
   task automatic test_reset_keys();
      send_word(1'b0, '0, '0, 1'b0);
      send_word(1'b0, '1, '1, 1'b1);
      send_word(1'b1, '1, 32'hA5A5_5A5A, 1'b0);
      send_word(1'b1, '0, 32'h0123_4567, 1'b1);
   endtask

   task automatic test_directed_keys();
      sender_idles    = 1'b1;
      receiver_stalls = 1'b1;
      load_keys(KEYS_RANDOM);
      // an all-ones key0 word 0 pushes loaded positions past 32 bits
      write_key_pair(KEY_PAIR_0_IDX, '1);
      send_word(1'b1, '0, '0, 1'b0);
      for (int i = 1; i < KEY_COUNT; i++)
         send_word(1'b0, $urandom, '1, i == KEY_COUNT - 1);
      send_word(1'b1, '1, '1, 1'b1);   // highest position a load can reach
      send_word(1'b0, '1, 32'h8000_0001, 1'b0);
      quiesce();
      write_key_pair(KEY_PAIR_0_IDX, {$urandom, 32'h0});
      send_word(1'b1, 32'd0, $urandom, 1'b0);   // position zero, no keystream
      send_word(1'b1, 32'd31, $urandom, 1'b0);  // next word starts the key1 term
      send_word(1'b0, '0, $urandom, 1'b1);
      send_word(1'b1, 32'd1000, $urandom, 1'b0);
      send_word(1'b1, 32'd7, $urandom, 1'b1);
      load_keys(KEYS_ONES);
      send_word(1'b1, '1, '1, 1'b0);
      send_word(1'b0, '0, '0, 1'b1);
      send_word(1'b1, '0, 32'h5555_5555, 1'b1);
   endtask

   // mostly well-formed buffers: a position load, then words up to a last flag
   task automatic test_random_streams(input int phases, input int words_per_phase);
      int target;
      int len;
      bit tidy;
      logic [WORD_W-1:0] offset;
      for (int phase = 0; phase < phases; phase++) begin
         if (phase == 0) load_keys(KEYS_ZERO);
         else if (phase == 1) load_keys(KEYS_ONES);
         else load_keys(KEYS_RANDOM);
         sender_idles    = (phase % 2) == 1;
         receiver_stalls = ((phase / 2) % 2) == 1;
         target = words_driven + words_per_phase;
         while (words_driven < target) begin
            len    = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 64)
                                                 : $urandom_range(1, 16);
            tidy   = $urandom_range(0, 6) != 0;
            offset = pick_offset();
            for (int w = 0; w < len; w++) begin
               if (tidy)
                  send_word(w == 0, (w == 0) ? offset : $urandom, $urandom, w == len - 1);
               else
                  send_word($urandom_range(0, 3) == 0, pick_offset(), $urandom,
                            $urandom_range(0, 1) == 1);
            end
            // now and then let the pipeline run dry before the next buffer
            if ($urandom_range(0, 24) == 0) wait_drained();
         end
      end
   endtask

   initial begin : stimulus
      int waited;
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_set_position = 1'b0;
      req_word_offset  = '0;
      req_data_word    = '0;
      req_last_word    = 1'b0;
      csr_wr_en        = 1'b0;
      csr_index        = '0;
      csr_wdata        = '0;
      cipher_keys      = '0;
      word_position    = '0;
      sender_idles     = 1'b0;
      receiver_stalls  = 1'b0;
      words_driven     = 0;
      results_checked  = 0;
      mismatch_count   = 0;
      key_settings     = 1;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_reset_keys();
      test_directed_keys();
      test_random_streams(8, 200);

      @(negedge clock);
      req_valid <= 1'b0;
      waited = 0;
      while (pending_results.size() != 0 && waited < END_WAIT_LIMIT) begin
         @(negedge clock);
         waited++;
      end
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (pending_results.size() != 0) begin
         mismatch_count += pending_results.size();
         $display("%0t: %0d expected transactions never came out",
                  $time, pending_results.size());
      end

      $display("Coded %0d words under %0d key settings, %0d transactions compared",
               words_driven, key_settings, results_checked);
      $display("Buffers mixed position loads, last flags, idles and back-pressure; %0d mismatches",
               mismatch_count);
      if (mismatch_count == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

   initial begin : watchdog
      #40ms;
      $display("%0t: run did not finish in time", $time);
      $display("Verification failed");
      $finish;
   end

endmodule
